// ===== hw/rtl/lrpd_pkg.sv =====
// Shared constants and types of the laser line row peak detector.
// Used by the background RAM and the top level; depends on nothing.
`timescale 1ns / 1ps

package lrpd_pkg;

  // Frame size limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 512;

  // Counter widths hold the limit itself; index widths address inside it
  localparam int COL_W     = $clog2(MAX_COLS + 1);
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);

  // Background frame store
  localparam int BG_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int BG_ADDR_W = $clog2(BG_DEPTH);

  // Field widths of the stream payloads
  localparam int PIX_W     = 8;
  localparam int PCOL_W    = 10;
  localparam int PROW_W    = 9;
  localparam int THR_RESET = 20;

  // Request to the single port background RAM
  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [BG_ADDR_W-1:0] addr;
    logic [PIX_W-1:0]     wdata;
  } lrpd_ram_req_t;

endpackage

// ===== hw/rtl/lrpd_bg_ram.sv =====
// Single port background frame memory with registered read data.
// Depends on lrpd_pkg for depth, widths and the request struct.
`timescale 1ns / 1ps

module lrpd_bg_ram (
  input  logic                      clk,
  input  lrpd_pkg::lrpd_ram_req_t   req,
  output logic [lrpd_pkg::PIX_W-1:0] rdata
);

  logic [lrpd_pkg::PIX_W-1:0] mem [0:lrpd_pkg::BG_DEPTH-1];

  // Write on a write request, register read data otherwise; hold when idle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ===== hw/rtl/laser_line_row_peak_detect.sv =====
// Laser line row peak detector: background subtraction, threshold and per row peak search.
// Depends on lrpd_pkg and instantiates lrpd_bg_ram.
`timescale 1ns / 1ps

// Accepts one pixel per clock in raster order and emits one result per row at the
// row's end (tlast or end of frame): row index and the column and value of the first
// strictly greatest thresholded difference, or peak_found low. A pixel flagged
// store_as_base writes the background frame; until a background exists, and from the
// first stored pixel to the end of that frame, differences are zero. Pixels beyond
// the column or row limits are ignored, and rows beyond the row limit emit nothing.
// Each in-range pixel makes one access to the single port background RAM (write
// when stored, read otherwise), and the difference, threshold and running max are
// done in the cycle after. The input stalls only while a row result waits behind a
// full, stalled output register. No clearing pass is needed: background entries that
// were never written read as undefined. The user must write the threshold only
// while the block is idle; the block itself does not enforce it.

module laser_line_row_peak_detect (
  input  logic        clk,
  input  logic        rst,
  // Pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] pixel
  input  logic [1:0]  s_tuser,  // [0] store_as_base, [1] end_of_frame
  input  logic        s_tlast,  // end_of_row
  // Row result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [9:0] peak_column, [17:10] peak_value, [26:18] row_index
  output logic [0:0]  m_tuser,  // [0] peak_found
  // Threshold register
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int PW = lrpd_pkg::PIX_W;

  // Stage 0 state
  logic [lrpd_pkg::COL_W-1:0] col_cnt;
  logic [lrpd_pkg::ROW_W-1:0] row_cnt;
  logic                       bg_valid;
  logic                       capture;
  logic [PW-1:0]              threshold;

  // Stage 1 registers
  logic                           s1_valid;
  logic [PW-1:0]                  s1_pix;
  logic                           s1_use;
  logic                           s1_inr;
  logic [lrpd_pkg::COL_IDX_W-1:0] s1_col;
  logic                           s1_last;
  logic                           s1_emit;
  logic [lrpd_pkg::ROW_IDX_W-1:0] s1_row;

  // Running row peak
  logic [PW-1:0]                  best_value;
  logic [lrpd_pkg::COL_IDX_W-1:0] best_column;

  // Output register
  logic                        out_valid;
  logic                        out_found;
  logic [lrpd_pkg::PCOL_W-1:0] out_col;
  logic [PW-1:0]               out_val;
  logic [lrpd_pkg::PROW_W-1:0] out_row;

  logic                    accept;
  logic                    s1_block;
  logic                    s1_fire;
  logic                    in_range;
  logic                    row_ok;
  logic                    pix_last;
  logic                    store;
  logic                    eof;
  logic [PW-1:0]           bg_rdata;
  logic [PW-1:0]           diff;
  logic [PW-1:0]           thr_diff;
  logic                    better;
  logic [PW-1:0]           nb_value;
  logic [lrpd_pkg::COL_IDX_W-1:0] nb_column;
  lrpd_pkg::lrpd_ram_req_t ram_req;

  // Handshake and stall
  assign s1_block = s1_valid && s1_emit && out_valid && !m_tready;
  assign s1_fire  = s1_valid && !s1_block;
  assign s_tready = !s1_block;
  assign accept   = s_tvalid && s_tready;

  // Decode the request
  assign store    = s_tuser[0];
  assign eof      = s_tuser[1];
  assign pix_last = s_tlast || eof;
  assign row_ok   = row_cnt < lrpd_pkg::ROW_W'(lrpd_pkg::MAX_ROWS);
  assign in_range = row_ok && (col_cnt < lrpd_pkg::COL_W'(lrpd_pkg::MAX_COLS));

  // Background access: for in-range pixels, write stored ones and read all others
  always_comb begin
    ram_req.en    = accept && in_range;
    ram_req.we    = store;
    ram_req.addr  = lrpd_pkg::BG_ADDR_W'(
                      row_cnt[lrpd_pkg::ROW_IDX_W-1:0] * lrpd_pkg::BG_ADDR_W'(lrpd_pkg::MAX_COLS)
                      + lrpd_pkg::BG_ADDR_W'(col_cnt[lrpd_pkg::COL_IDX_W-1:0]));
    ram_req.wdata = s_tdata[PW-1:0];
  end

  lrpd_bg_ram u_bg_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (bg_rdata)
  );

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= PW'(lrpd_pkg::THR_RESET);
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Stage 0: advance counters and capture flags on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      bg_valid <= 1'b0;
      capture  <= 1'b0;
    end else if (accept) begin
      if (in_range && store) begin
        bg_valid <= 1'b1;
        capture  <= 1'b1;
      end
      if (pix_last) begin
        col_cnt <= '0;
        if (eof) begin
          row_cnt <= '0;
          capture <= 1'b0;
        end else if (row_ok) begin
          row_cnt <= row_cnt + 1'b1;
        end
      end else if (col_cnt < lrpd_pkg::COL_W'(lrpd_pkg::MAX_COLS)) begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // Stage 1 pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_block) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= s_tdata[PW-1:0];
      s1_use  <= !store && bg_valid && !capture;
      s1_inr  <= in_range;
      s1_col  <= col_cnt[lrpd_pkg::COL_IDX_W-1:0];
      s1_last <= pix_last;
      s1_emit <= pix_last && row_ok;
      s1_row  <= row_cnt[lrpd_pkg::ROW_IDX_W-1:0];
    end
  end

  // Stage 1: saturating difference, threshold, running max
  always_comb begin
    diff      = (s1_use && (s1_pix > bg_rdata)) ? PW'(s1_pix - bg_rdata) : '0;
    thr_diff  = (diff > threshold) ? diff : '0;
    better    = s1_inr && (thr_diff > best_value);
    nb_value  = better ? thr_diff : best_value;
    nb_column = better ? s1_col : best_column;
  end

  // Hold the row peak, clear it at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      best_value  <= '0;
      best_column <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        best_value  <= '0;
        best_column <= '0;
      end else begin
        best_value  <= nb_value;
        best_column <= nb_column;
      end
    end
  end

  // Output register: load a row result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_found <= nb_value != '0;
      out_col   <= (nb_value != '0) ? lrpd_pkg::PCOL_W'(nb_column) : '0;
      out_val   <= nb_value;
      out_row   <= lrpd_pkg::PROW_W'(s1_row);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = {5'b0, out_row, out_val, out_col};

  // Checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_emit && out_valid))
    else $error("input stalled without a pending row result");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_col == '0 && out_val == '0))
    else $error("no-peak result carries nonzero column or value");

  a_best_consistent: assert property (@(posedge clk) disable iff (rst)
    (best_value == '0) |-> (best_column == '0))
    else $error("peak column set without a peak value");

  a_counter_limits: assert property (@(posedge clk) disable iff (rst)
    (col_cnt <= lrpd_pkg::COL_W'(lrpd_pkg::MAX_COLS))
    && (row_cnt <= lrpd_pkg::ROW_W'(lrpd_pkg::MAX_ROWS)))
    else $error("position counter beyond its limit");

  a_result_follows_row_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_emit))
    else $error("result appeared without a finished row");

endmodule
